// ----- rtl/core/date_add_days_julian_defines.svh -----
// Assertion macros for the date adder.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef DATE_ADD_DAYS_JULIAN_DEFINES_SVH
`define DATE_ADD_DAYS_JULIAN_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DAJD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dajd: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DAJD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dajd: next-cycle check failed");

`endif

// ----- rtl/core/dajd_pkg.sv -----
// Shared types, constants and the month offset table for the date adder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dajd_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned ADD_W   = 16;
   localparam int unsigned JDN_W   = 23;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned FRONT_STAGES = 3;
   localparam int unsigned BACK_STAGES  = 7;

   // Forward conversion
   localparam int unsigned YEAR_BIAS = 4800;
   localparam int unsigned JDN_BIAS  = 32045;
   localparam int unsigned DAYS_YEAR = 365;
   localparam int unsigned RECIP_100 = 5243;   // ceil(2^19 / 100), exact for y < 2^15
   localparam int unsigned SHIFT_100 = 19;
   localparam int unsigned MONTH_FEB = 2;

   // Reverse conversion: floor reciprocals give the quotient or one below; RECIP_5 is a ceiling
   localparam int unsigned X_BIAS     = 4 * 32044 + 3;
   localparam int unsigned DAYS_400Y  = 146097;
   localparam int unsigned RECIP_400Y = 229;
   localparam int unsigned SHIFT_400Y = 25;
   localparam int unsigned DAYS_4Y    = 1461;
   localparam int unsigned RECIP_4Y   = 179;
   localparam int unsigned SHIFT_4Y   = 18;
   localparam int unsigned DAYS_5M    = 153;
   localparam int unsigned RECIP_5M   = 13;
   localparam int unsigned SHIFT_5M   = 11;
   localparam int unsigned RECIP_5    = 205;
   localparam int unsigned SHIFT_5    = 10;
   localparam int unsigned MONTH_WRAP = 10;

   localparam int unsigned YEAR_MAX     = 9999;
   localparam int unsigned YEAR_MIN     = 1;
   localparam int unsigned YEAR_RAW_MAX = YEAR_MAX + YEAR_BIAS;
   localparam int unsigned YEAR_RAW_MIN = YEAR_MIN + YEAR_BIAS;

   typedef struct packed {
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [ADD_W-1:0]   add_days;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  result_year;
      logic [MONTH_W-1:0] result_month;
      logic [DAY_W-1:0]   result_day;
      logic [JDN_W-1:0]   day_number;
      logic               year_overflow;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Days from 1 March to the start of March-based month m: (153 * m + 2) / 5
   function automatic logic [8:0] month_days(input logic [MONTH_W-1:0] m);
      logic [8:0] days;
      case (m)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         4'd12:   days = 9'd367;
         4'd13:   days = 9'd398;
         4'd14:   days = 9'd428;
         default: days = 9'd459;
      endcase
      return days;
   endfunction

endpackage

// ----- rtl/core/date_add_days_julian.sv -----
// Date adder top level: front end, day number queue and back end.
// Depends on dajd_pkg, dajd_front, dajd_queue, dajd_back and the assertion macros.
//
// Usage:
//   A request beat carries a Gregorian date and a day count; it is taken at a
//   rising edge with req_valid high and req_stall low. Each request gives
//   exactly one response beat, in order, taken when rsp_valid is high and
//   rsp_stall is low. The response holds the new date (year saturated to
//   1..9999, year_overflow set above 9999) and its Julian Day Number.
//   Throughput is one beat per cycle while no stall is raised. After the
//   accepting edge, on which the first of three front stages loads, a beat
//   passes two more front stages, the queue and eight back stages including
//   the output register before rsp_valid rises.
//   While a result waits on rsp_stall the back end holds it and freezes; the
//   front end keeps taking requests into the four-entry queue, and req_stall
//   rises only when the queue is full and the front's last stage is occupied.
//   Synchronous reset clears all valid bits and empties the queue; the block
//   takes a request in the first cycle after reset.
`timescale 1ns / 1ps
`include "date_add_days_julian_defines.svh"

module date_add_days_julian
   import dajd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             push;
   logic [JDN_W-1:0] push_jdn;
   logic             pop;
   logic [JDN_W-1:0] pop_jdn;
   queue_status_type q_status;

   dajd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_jdn  (push_jdn),
      .q_status  (q_status)
   );

   dajd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_jdn (push_jdn),
      .pop      (pop),
      .pop_jdn  (pop_jdn),
      .q_status (q_status)
   );

   dajd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_jdn   (pop_jdn),
      .q_status  (q_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `DAJD_ASSERT_NOW(a_pop_not_empty, pop, !q_status.empty)
   `DAJD_ASSERT_NOW(a_push_not_full, push, !q_status.full)
   `DAJD_ASSERT_NEXT(a_push_fills, push && !pop, !q_status.empty)
   `DAJD_ASSERT_NEXT(a_pop_drains, pop && !push, !q_status.full)

endmodule

// ----- rtl/core/dajd_front.sv -----
// Front end: takes request beats and turns the date plus offset into a day number.
// Three stages (decode, multiply, sum); depends on dajd_pkg.
`timescale 1ns / 1ps

module dajd_front
   import dajd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             push,
   output logic [JDN_W-1:0] push_jdn,
   input  queue_status_type q_status
);

   logic                    en;
   logic [FRONT_STAGES-1:0] vld_ff, vld_in;

   logic                    shift;
   logic [MONTH_W-1:0]      mar_month;
   logic [14:0]             f1_y_ff, f1_y_in;
   logic [16:0]             f1_small_ff, f1_small_in;

   logic [23:0]             p365;
   logic [26:0]             p100;
   logic [25:0]             p400;
   logic [22:0]             f2_p365_ff, f2_p365_in;
   logic [12:0]             f2_y4_ff, f2_y4_in;
   logic [7:0]              f2_q100_ff, f2_q100_in;
   logic [5:0]              f2_q400_ff, f2_q400_in;
   logic [16:0]             f2_small_ff, f2_small_in;

   logic [23:0]             jdn_sum;
   logic [JDN_W-1:0]        f3_jdn_ff, f3_jdn_in;

   // hold the whole front while a finished beat cannot enter the queue
   assign en        = !vld_ff[FRONT_STAGES-1] || !q_status.full;
   assign req_stall = !en;
   assign push      = vld_ff[FRONT_STAGES-1] && !q_status.full;
   assign push_jdn  = f3_jdn_ff;

   assign vld_in = {vld_ff[FRONT_STAGES-2:0], req_valid};

   // decode: January and February belong to the previous March-based year
   always_comb begin
      shift       = (req_data.start_month <= MONTH_W'(MONTH_FEB));
      mar_month   = shift ? (req_data.start_month + 4'd9) : (req_data.start_month - 4'd3);
      f1_y_in     = 15'(req_data.start_year) + 15'(YEAR_BIAS) - 15'(shift);
      f1_small_in = 17'(req_data.start_day) + 17'(month_days(mar_month))
                    + 17'(req_data.add_days);
   end

   // multiply: 365 y, y / 100 and y / 400 by reciprocal
   always_comb begin
      p365        = 24'(f1_y_ff) * 24'(DAYS_YEAR);
      p100        = 27'(f1_y_ff) * 27'(RECIP_100);
      p400        = 26'(f1_y_ff[14:2]) * 26'(RECIP_100);
      f2_p365_in  = p365[22:0];
      f2_y4_in    = f1_y_ff[14:2];
      f2_q100_in  = p100[SHIFT_100 +: 8];
      f2_q400_in  = p400[SHIFT_100 +: 6];
      f2_small_in = f1_small_ff;
   end

   // sum the terms into the day number
   always_comb begin
      jdn_sum   = 24'(f2_p365_ff) + 24'(f2_y4_ff) + 24'(f2_q400_ff) + 24'(f2_small_ff)
                  - 24'(f2_q100_ff) - 24'(JDN_BIAS);
      f3_jdn_in = jdn_sum[JDN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_y_ff     <= f1_y_in;
         f1_small_ff <= f1_small_in;
         f2_p365_ff  <= f2_p365_in;
         f2_y4_ff    <= f2_y4_in;
         f2_q100_ff  <= f2_q100_in;
         f2_q400_ff  <= f2_q400_in;
         f2_small_ff <= f2_small_in;
         f3_jdn_ff   <= f3_jdn_in;
      end
   end

endmodule

// ----- rtl/core/dajd_queue.sv -----
// Short register queue of day numbers between the front and back ends.
// Depth from dajd_pkg; reports empty and full as a status struct.
`timescale 1ns / 1ps

module dajd_queue
   import dajd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [JDN_W-1:0] push_jdn,
   input  logic             pop,
   output logic [JDN_W-1:0] pop_jdn,
   output queue_status_type q_status
);

   logic [JDN_W-1:0]    mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign pop_jdn        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_jdn;
      end
   end

endmodule

// ----- rtl/core/dajd_back.sv -----
// Back end: turns a day number into year, month and day, and drives the result beat.
// Seven stages plus the output register; depends on dajd_pkg.
`timescale 1ns / 1ps

module dajd_back
   import dajd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   output logic             pop,
   input  logic [JDN_W-1:0] pop_jdn,
   input  queue_status_type q_status,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic                   en;
   logic [BACK_STAGES-1:0] vld_ff, vld_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   // stage 1: x = 4 a + 3, estimate of x / 146097
   logic [24:0]      b1_x;
   logic [32:0]      b1_prod;
   logic [24:0]      b1_x_ff, b1_x_in;
   logic [7:0]       b1_q_ff, b1_q_in;
   logic [JDN_W-1:0] b1_jdn_ff;

   // stage 2: correct, c = remainder / 4
   logic [25:0]      b2_prod, b2_rem;
   logic [18:0]      b2_r0;
   logic [17:0]      b2_r;
   logic             b2_ge;
   logic [7:0]       b2_b_ff, b2_b_in;
   logic [15:0]      b2_c_ff, b2_c_in;
   logic [JDN_W-1:0] b2_jdn_ff;

   // stage 3: estimate of (4 c + 3) / 1461
   logic [17:0]      b3_x;
   logic [25:0]      b3_prod;
   logic [17:0]      b3_x_ff, b3_x_in;
   logic [6:0]       b3_q_ff, b3_q_in;
   logic [7:0]       b3_b_ff;
   logic [JDN_W-1:0] b3_jdn_ff;

   // stage 4: correct, e = remainder / 4
   logic [17:0]      b4_prod, b4_rem;
   logic [11:0]      b4_r0;
   logic [10:0]      b4_r;
   logic             b4_ge;
   logic [6:0]       b4_d_ff, b4_d_in;
   logic [8:0]       b4_e_ff, b4_e_in;
   logic [7:0]       b4_b_ff;
   logic [JDN_W-1:0] b4_jdn_ff;

   // stage 5: estimate of (5 e + 2) / 153
   logic [10:0]      b5_x;
   logic [14:0]      b5_prod;
   logic [10:0]      b5_x_ff, b5_x_in;
   logic [3:0]       b5_q_ff, b5_q_in;
   logic [6:0]       b5_d_ff;
   logic [7:0]       b5_b_ff;
   logic [JDN_W-1:0] b5_jdn_ff;

   // stage 6: correct, keep March-based month and its remainder
   logic [11:0]      b6_prod, b6_rem;
   logic [8:0]       b6_r0;
   logic             b6_ge;
   logic [3:0]       b6_m_ff, b6_m_in;
   logic [7:0]       b6_rm_ff, b6_rm_in;
   logic [6:0]       b6_d_ff;
   logic [7:0]       b6_b_ff;
   logic [JDN_W-1:0] b6_jdn_ff;

   // stage 7: assemble year, month and day
   logic             b7_tail;
   logic [15:0]      b7_prod;
   logic [14:0]      b7_yr_ff, b7_yr_in;
   logic [MONTH_W-1:0] b7_month_ff, b7_month_in;
   logic [DAY_W-1:0] b7_day_ff, b7_day_in;
   logic [JDN_W-1:0] b7_jdn_ff;

   // freeze the whole back end only while a result beat waits on a stall
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign pop       = en && !q_status.empty;
   assign vld_in    = {vld_ff[BACK_STAGES-2:0], !q_status.empty};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      b1_x    = 25'({pop_jdn, 2'b00}) + 25'(X_BIAS);
      b1_prod = 33'(b1_x) * 33'(RECIP_400Y);
      b1_x_in = b1_x;
      b1_q_in = b1_prod[SHIFT_400Y +: 8];
   end

   always_comb begin
      b2_prod = 26'(b1_q_ff) * 26'(DAYS_400Y);
      b2_rem  = 26'(b1_x_ff) - b2_prod;
      b2_r0   = b2_rem[18:0];
      b2_ge   = (b2_r0 >= 19'(DAYS_400Y));
      b2_r    = b2_ge ? 18'(b2_r0 - 19'(DAYS_400Y)) : b2_r0[17:0];
      b2_b_in = b1_q_ff + 8'(b2_ge);
      b2_c_in = b2_r[17:2];
   end

   always_comb begin
      b3_x    = {b2_c_ff, 2'b11};
      b3_prod = 26'(b3_x) * 26'(RECIP_4Y);
      b3_x_in = b3_x;
      b3_q_in = b3_prod[SHIFT_4Y +: 7];
   end

   always_comb begin
      b4_prod = 18'(b3_q_ff) * 18'(DAYS_4Y);
      b4_rem  = b3_x_ff - b4_prod;
      b4_r0   = b4_rem[11:0];
      b4_ge   = (b4_r0 >= 12'(DAYS_4Y));
      b4_r    = b4_ge ? 11'(b4_r0 - 12'(DAYS_4Y)) : b4_r0[10:0];
      b4_d_in = b3_q_ff + 7'(b4_ge);
      b4_e_in = b4_r[10:2];
   end

   always_comb begin
      b5_x    = 11'({b4_e_ff, 2'b00}) + 11'(b4_e_ff) + 11'd2;
      b5_prod = 15'(b5_x) * 15'(RECIP_5M);
      b5_x_in = b5_x;
      b5_q_in = b5_prod[SHIFT_5M +: 4];
   end

   always_comb begin
      b6_prod  = 12'(b5_q_ff) * 12'(DAYS_5M);
      b6_rem   = 12'(b5_x_ff) - b6_prod;
      b6_r0    = b6_rem[8:0];
      b6_ge    = (b6_r0 >= 9'(DAYS_5M));
      b6_m_in  = b5_q_ff + 4'(b6_ge);
      b6_rm_in = b6_ge ? 8'(b6_r0 - 9'(DAYS_5M)) : b6_r0[7:0];
   end

   // months ten and eleven of the March-based year are January and February
   always_comb begin
      b7_tail     = (b6_m_ff >= 4'(MONTH_WRAP));
      b7_prod     = 16'(b6_rm_ff) * 16'(RECIP_5);
      b7_yr_in    = 15'(b6_b_ff) * 15'd100 + 15'(b6_d_ff) + 15'(b7_tail);
      b7_month_in = b7_tail ? (b6_m_ff - 4'd9) : (b6_m_ff + 4'd3);
      b7_day_in   = b7_prod[SHIFT_5 +: DAY_W] + 5'd1;
   end

   // saturate the year to the supported range
   always_comb begin
      rsp_in.result_month = b7_month_ff;
      rsp_in.result_day   = b7_day_ff;
      rsp_in.day_number   = b7_jdn_ff;
      if (b7_yr_ff > 15'(YEAR_RAW_MAX)) begin
         rsp_in.result_year   = YEAR_W'(YEAR_MAX);
         rsp_in.year_overflow = 1'b1;
      end else if (b7_yr_ff < 15'(YEAR_RAW_MIN)) begin
         rsp_in.result_year   = YEAR_W'(YEAR_MIN);
         rsp_in.year_overflow = 1'b0;
      end else begin
         rsp_in.result_year   = YEAR_W'(b7_yr_ff - 15'(YEAR_BIAS));
         rsp_in.year_overflow = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[BACK_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_x_ff     <= b1_x_in;
         b1_q_ff     <= b1_q_in;
         b1_jdn_ff   <= pop_jdn;
         b2_b_ff     <= b2_b_in;
         b2_c_ff     <= b2_c_in;
         b2_jdn_ff   <= b1_jdn_ff;
         b3_x_ff     <= b3_x_in;
         b3_q_ff     <= b3_q_in;
         b3_b_ff     <= b2_b_ff;
         b3_jdn_ff   <= b2_jdn_ff;
         b4_d_ff     <= b4_d_in;
         b4_e_ff     <= b4_e_in;
         b4_b_ff     <= b3_b_ff;
         b4_jdn_ff   <= b3_jdn_ff;
         b5_x_ff     <= b5_x_in;
         b5_q_ff     <= b5_q_in;
         b5_d_ff     <= b4_d_ff;
         b5_b_ff     <= b4_b_ff;
         b5_jdn_ff   <= b4_jdn_ff;
         b6_m_ff     <= b6_m_in;
         b6_rm_ff    <= b6_rm_in;
         b6_d_ff     <= b5_d_ff;
         b6_b_ff     <= b5_b_ff;
         b6_jdn_ff   <= b5_jdn_ff;
         b7_yr_ff    <= b7_yr_in;
         b7_month_ff <= b7_month_in;
         b7_day_ff   <= b7_day_in;
         b7_jdn_ff   <= b6_jdn_ff;
         rsp_ff      <= rsp_in;
      end
   end

endmodule
